FILE: design/bcsh_pkg.sv
// Shared types, constants and arithmetic helpers for the bit crusher with sample and hold.
`timescale 1ns / 1ps
`default_nettype none

package bcsh_pkg;

	// Frame layout.
	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 16;
	localparam int TDATA_W     = CHANNELS * SAMPLE_BITS;

	// Datapath widths.
	localparam int ACC_W = 34;
	localparam int OPD_W = 18;
	localparam int DIV_W = 24;
	localparam int MR1_W = 16;
	localparam int MR2_W = 10;
	localparam int CNT_W = 4;

	// Number of radix-4 digit steps in each serial phase.
	localparam logic [CNT_W-1:0] K_STEPS     = 4'd3;
	localparam logic [CNT_W-1:0] DIV_STEPS   = 4'd12;
	localparam logic [CNT_W-1:0] RECIP_STEPS = 4'd8;
	localparam logic [CNT_W-1:0] MIX_STEPS   = 4'd5;

	// The divide-by-ten runs on an unsigned dividend: 10 * 2^19 lifts any product above
	// zero, and the extra 5 is the rounding term of the drive division.
	localparam logic signed [ACC_W-1:0] DIV_BIAS    = 34'sd5242885;
	localparam logic signed [ACC_W-1:0] QUOT_OFFSET = 34'sd524288;

	// Rounding terms and saturation bounds.
	localparam logic signed [ACC_W-1:0] RND_Q15 = 34'sd16384;
	localparam logic signed [ACC_W-1:0] RND_MIX = 34'sd128;
	localparam logic signed [ACC_W-1:0] SAT_HI  = 34'sd32767;
	localparam logic signed [ACC_W-1:0] SAT_LO  = -34'sd32768;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BYPASS    = 2'd0,
		REG_BIT_DEPTH = 2'd1,
		REG_RATE      = 2'd2,
		REG_WET_MIX   = 2'd3
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULK,
		ST_BIAS,
		ST_DIV,
		ST_HOLD,
		ST_QUANT,
		ST_RECIP,
		ST_WET,
		ST_MIX,
		ST_OUT
	} state_t;

	// Q1.15 reciprocal of the drive gain, indexed by bit depth minus one.
	function automatic logic [15:0] recip_q15(input logic [3:0] idx);
		logic [15:0] r;
		case (idx)
			4'd0:    r = 16'd4681;
			4'd1:    r = 16'd4965;
			4'd2:    r = 16'd5285;
			4'd3:    r = 16'd5650;
			4'd4:    r = 16'd6068;
			4'd5:    r = 16'd6554;
			4'd6:    r = 16'd7123;
			4'd7:    r = 16'd7802;
			4'd8:    r = 16'd8623;
			4'd9:    r = 16'd9638;
			4'd10:   r = 16'd10923;
			4'd11:   r = 16'd12603;
			4'd12:   r = 16'd14895;
			4'd13:   r = 16'd18204;
			4'd14:   r = 16'd23406;
			default: r = 16'd32768;
		endcase
		return r;
	endfunction

	// Signed operand times one unsigned radix-4 digit.
	function automatic logic signed [ACC_W-1:0] mul_digit(
		input logic signed [OPD_W-1:0] a,
		input logic [1:0] d
	);
		logic signed [ACC_W-1:0] ax;
		logic signed [ACC_W-1:0] p1;
		logic signed [ACC_W-1:0] p2;
		ax = ACC_W'(a);
		p2 = d[1] ? (ax <<< 1) : '0;
		p1 = d[0] ? ax : '0;
		return p2 + p1;
	endfunction

	// Clamp a wide signed value to the sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/bit_crusher_sample_hold.sv
// Stereo bit crusher with sample-and-hold rate reduction, built on radix-4 serial arithmetic.
`timescale 1ns / 1ps
`default_nettype none

// One request on the slave stream carries a stereo Q1.15 frame and yields exactly one output
// frame on the master stream. Each frame taken outside bypass advances a Q8.8 phase by one;
// when it reaches rate_reduction the hold registers take the input times the drive gain 1 +
// (16 - bits) * 0.4. The held value is rounded to the chosen bit depth, divided by the drive
// through a reciprocal table and blended with the dry sample by wet_mix. Both channels run
// side by side in their own lanes under one sequencer, and every product and the divide by
// ten are formed two bits per cycle. After the request is taken, a processed frame runs 3
// drive multiply steps, a bias step, 12 divide steps, a hold step, a quantize step, 8
// reciprocal multiply steps, a step to round the wet value, 5 mix steps and the output write,
// which waits until the output register is free. In bypass a frame skips to the output write.
// A new request is taken while the previous result still waits in the output register. The
// user must write registers only while no frame is in flight; the block does not enforce it.
module bit_crusher_sample_hold
	import bcsh_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input frame stream.
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,   // [15:0] in_left, [31:16] in_right
	// Output frame stream.
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // [15:0] out_left, [31:16] out_right
	// Register write port.
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [15:0]        cfg_data
);

	// Configuration registers.
	logic        bypass_q;
	logic [4:0]  bit_depth_q;
	logic [15:0] rate_q;
	logic [8:0]  wet_mix_q;

	// Sequencer and frame state.
	state_t                 state_q;
	state_t                 state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       cnt_d;
	logic                   out_valid_q;
	logic [16:0]            phase_q;
	logic                   load_q;
	logic signed [SAMPLE_BITS-1:0] held_q [CHANNELS];

	// Lane datapath registers.
	logic signed [SAMPLE_BITS-1:0] dry_q [CHANNELS];
	logic signed [ACC_W-1:0]       acc_q [CHANNELS];
	logic signed [OPD_W-1:0]       opa_q [CHANNELS];
	logic signed [OPD_W-1:0]       opb_q [CHANNELS];
	logic [DIV_W-1:0]              dq_q  [CHANNELS];
	logic [3:0]                    rem_q [CHANNELS];
	logic [SAMPLE_BITS-1:0]        out_q [CHANNELS];

	// Shared multiplier digit registers.
	logic [MR1_W-1:0] mr1_q;
	logic [MR2_W-1:0] mr2_q;

	// Lane combinational results.
	logic signed [ACC_W-1:0]       acc_step  [CHANNELS];
	logic [DIV_W-1:0]              div_init  [CHANNELS];
	logic [DIV_W-1:0]              dq_next   [CHANNELS];
	logic [3:0]                    rem_next  [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] hold_new  [CHANNELS];
	logic signed [OPD_W-1:0]       quant_val [CHANNELS];
	logic signed [OPD_W-1:0]       wet_val   [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] mix_out   [CHANNELS];

	// Derived controls.
	logic        accept;
	logic        out_load;
	logic [4:0]  b_eff;
	logic [3:0]  b_idx;
	logic [5:0]  k_val;
	logic [3:0]  q_shift;
	logic [8:0]  mix_eff;
	logic [8:0]  dry_wt;
	logic [16:0] rate_eff;
	logic [16:0] phase_sum;
	logic        load_now;
	logic [16:0] phase_next;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Pack the output lanes, left channel in the low bits.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = out_q[c];
		end
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q    <= 1'b0;
			bit_depth_q <= 5'd8;
			rate_q      <= 16'd256;
			wet_mix_q   <= 9'd256;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_BYPASS:    bypass_q    <= cfg_data[0];
				REG_BIT_DEPTH: bit_depth_q <= cfg_data[4:0];
				REG_RATE:      rate_q      <= cfg_data;
				REG_WET_MIX:   wet_mix_q   <= cfg_data[8:0];
				default:       bypass_q    <= bypass_q;
			endcase
		end
	end

	// Clamp the registers to their working ranges and derive the per-depth constants.
	always_comb begin
		if (bit_depth_q == 5'd0) begin
			b_eff = 5'd1;
		end else if (bit_depth_q > 5'd16) begin
			b_eff = 5'd16;
		end else begin
			b_eff = bit_depth_q;
		end
		b_idx    = 4'(b_eff - 5'd1);
		k_val    = 6'd37 - {b_eff, 1'b0};
		q_shift  = 4'(5'd16 - b_eff);
		mix_eff  = (wet_mix_q > 9'd256) ? 9'd256 : wet_mix_q;
		dry_wt   = 9'd256 - mix_eff;
		rate_eff = {1'b0, (rate_q < 16'd256) ? 16'd256 : rate_q};
	end

	// Phase accumulator advance for the frame being taken.
	always_comb begin
		phase_sum  = phase_q + 17'd256;
		load_now   = (phase_sum >= rate_eff);
		phase_next = load_now ? (phase_sum - rate_eff) : phase_sum;
	end

	// Per-lane arithmetic.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			logic signed [ACC_W-1:0] bias_sum;
			logic [5:0]              t;
			logic signed [ACC_W-1:0] hold_wide;
			logic signed [16:0]      h_ext;
			logic signed [16:0]      half;
			logic [16:0]             qmask;
			logic [16:0]             qsum;
			logic signed [ACC_W-1:0] wsum;
			logic signed [ACC_W-1:0] msum;

			// One radix-4 multiply-accumulate step, most significant digit first.
			acc_step[c] = (acc_q[c] <<< 2)
				+ mul_digit(opa_q[c], mr1_q[MR1_W-1 -: 2])
				+ mul_digit(opb_q[c], mr2_q[MR2_W-1 -: 2]);

			// Dividend for the drive division: 2 * x * k + 5, lifted above zero.
			bias_sum    = (acc_q[c] <<< 1) + DIV_BIAS;
			div_init[c] = bias_sum[DIV_W-1:0];

			// One radix-4 digit of the divide by ten.
			t = {rem_q[c], dq_q[c][DIV_W-1 -: 2]};
			if (t >= 6'd30) begin
				rem_next[c] = 4'(t - 6'd30);
				dq_next[c]  = {dq_q[c][DIV_W-3:0], 2'd3};
			end else if (t >= 6'd20) begin
				rem_next[c] = 4'(t - 6'd20);
				dq_next[c]  = {dq_q[c][DIV_W-3:0], 2'd2};
			end else if (t >= 6'd10) begin
				rem_next[c] = 4'(t - 6'd10);
				dq_next[c]  = {dq_q[c][DIV_W-3:0], 2'd1};
			end else begin
				rem_next[c] = t[3:0];
				dq_next[c]  = {dq_q[c][DIV_W-3:0], 2'd0};
			end

			// Remove the lift from the quotient and saturate.
			hold_wide   = $signed(ACC_W'(dq_q[c][19:0])) - QUOT_OFFSET;
			hold_new[c] = sat_sample(hold_wide);

			// Round the held value to the step size, halves upward, and clip at the top.
			h_ext = 17'(held_q[c]);
			half  = $signed((17'd1 << q_shift) >> 1);
			qmask = 17'h1FFFF << q_shift;
			qsum  = (h_ext + half) & qmask;
			if (!qsum[16] && qsum[15]) begin
				quant_val[c] = OPD_W'(SAT_HI);
			end else begin
				quant_val[c] = OPD_W'($signed(qsum[15:0]));
			end

			// Scale the reciprocal product back to Q1.15.
			wsum       = acc_q[c] + RND_Q15;
			wet_val[c] = OPD_W'(wsum >>> 15);

			// Dry and wet blend out of 256.
			msum       = acc_q[c] + RND_MIX;
			mix_out[c] = sat_sample(msum >>> 8);
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (bypass_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_MULK;
						cnt_d   = K_STEPS - 4'd1;
					end
				end
			end
			ST_MULK: begin
				if (cnt_q == '0) begin
					state_d = ST_BIAS;
				end else begin
					cnt_d = cnt_q - 4'd1;
				end
			end
			ST_BIAS: begin
				state_d = ST_DIV;
				cnt_d   = DIV_STEPS - 4'd1;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_HOLD;
				end else begin
					cnt_d = cnt_q - 4'd1;
				end
			end
			ST_HOLD: begin
				state_d = ST_QUANT;
			end
			ST_QUANT: begin
				state_d = ST_RECIP;
				cnt_d   = RECIP_STEPS - 4'd1;
			end
			ST_RECIP: begin
				if (cnt_q == '0) begin
					state_d = ST_WET;
				end else begin
					cnt_d = cnt_q - 4'd1;
				end
			end
			ST_WET: begin
				state_d = ST_MIX;
				cnt_d   = MIX_STEPS - 4'd1;
			end
			ST_MIX: begin
				if (cnt_q == '0) begin
					state_d = ST_OUT;
				end else begin
					cnt_d = cnt_q - 4'd1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state, phase, hold registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= '0;
			load_q      <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				held_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (accept && !bypass_q) begin
				phase_q <= phase_next;
				load_q  <= load_now;
			end
			if ((state_q == ST_HOLD) && load_q) begin
				for (int c = 0; c < CHANNELS; c++) begin
					held_q[c] <= hold_new[c];
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Shared multiplier digits: loaded per phase, shifted two bits per step.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mr1_q <= {k_val, 10'd0};
					mr2_q <= '0;
				end
			end
			ST_MULK, ST_RECIP, ST_MIX: begin
				mr1_q <= mr1_q << 2;
				mr2_q <= mr2_q << 2;
			end
			ST_QUANT: begin
				mr1_q <= recip_q15(b_idx);
				mr2_q <= '0;
			end
			ST_WET: begin
				mr1_q <= {1'b0, dry_wt, 6'd0};
				mr2_q <= {1'b0, mix_eff};
			end
			default: begin
				mr1_q <= mr1_q;
			end
		endcase
	end

	// Lane datapath registers.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dry_q[c] <= $signed(s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]);
						opa_q[c] <= OPD_W'($signed(s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]));
						opb_q[c] <= '0;
						acc_q[c] <= '0;
					end
				end
				ST_MULK, ST_RECIP, ST_MIX: begin
					acc_q[c] <= acc_step[c];
				end
				ST_BIAS: begin
					dq_q[c]  <= div_init[c];
					rem_q[c] <= '0;
				end
				ST_DIV: begin
					dq_q[c]  <= dq_next[c];
					rem_q[c] <= rem_next[c];
				end
				ST_QUANT: begin
					opa_q[c] <= quant_val[c];
					opb_q[c] <= '0;
					acc_q[c] <= '0;
				end
				ST_WET: begin
					opa_q[c] <= OPD_W'(dry_q[c]);
					opb_q[c] <= wet_val[c];
					acc_q[c] <= '0;
				end
				ST_OUT: begin
					if (out_load) begin
						out_q[c] <= bypass_q ? dry_q[c] : mix_out[c];
					end
				end
				default: begin
					acc_q[c] <= acc_q[c];
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The phase only moves when a frame is taken outside bypass.
	a_phase_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && !bypass_q) |=> $stable(phase_q))
		else $error("phase accumulator moved without a processed request");

	// A result appears only after the sequencer reached its output step.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output valid rose outside the output step");

	// The divide-by-ten remainder stays below the divisor in every lane.
	for (genvar g = 0; g < CHANNELS; g++) begin : g_rem_chk
		a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ST_DIV) |-> (rem_q[g] < 4'd10))
			else $error("divider remainder out of range");
	end
`endif

endmodule

`default_nettype wire
